// ===== src/integer_field_formatter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer field formatter
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define IFMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define IFMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ifmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter package
// Transaction types, conversion codes, character constants and digit lookup.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    // Default parameter values
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 64;

    // Field width counter size (counts up to 127 characters)
    localparam int WIDTH_W = 7;

    // Conversion kinds
    localparam logic [2:0] OP_SDEC  = 3'd0;
    localparam logic [2:0] OP_UDEC  = 3'd1;
    localparam logic [2:0] OP_OCT   = 3'd2;
    localparam logic [2:0] OP_HEXL  = 3'd3;
    localparam logic [2:0] OP_HEXU  = 3'd4;

    // Digit register load modes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // ASCII characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    // Input transaction
    typedef struct packed {
        logic [2:0]         opcode;
        logic [31:0]        value;
        logic [WIDTH_W-1:0] field_width;
        logic               zero_pad;
        logic               left_justify;
        logic               alternate;
    } request_t;

    // Output transaction
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    // Commands from the sequencer to the digit register
    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       shift;
        logic [1:0] radix;
    } dig_cmd_t;

    // Map a digit to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'd0, d};
        else if (upper)
            c = CH_UA + {4'd0, d} - 8'd10;
        else
            c = CH_LA + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

// ===== src/ifmt_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter digit register
// Shift register of 4-bit digits: loads octal or hex groups directly, builds
// decimal digits one input bit per cycle (shift and add three), and shifts
// digits out most significant first.
// ----------------------------------------------------------------------------
module ifmt_digits #(
    parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
    parameter int NDIG       = 22
) (
    input  logic                  clk,
    input  ifmt_pkg::dig_cmd_t    ctl,
    input  logic [VALUE_BITS-1:0] mag,
    output logic [3:0]            top_digit
);

    localparam int DW = NDIG * 4;

    logic [NDIG-1:0][3:0]  dig_reg, dig_next;
    logic [NDIG-1:0][3:0]  corr;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]         magx;

    // Add three to every digit of five or more ahead of the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            corr[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
    end

    assign magx = DW'(mag);

    // Select load, conversion step or digit shift
    always_comb
    begin
        dig_next = dig_reg;
        bin_next = bin_reg;
        if (ctl.load)
        begin
            bin_next = mag;
            for (int i = 0; i < NDIG; i++)
            begin
                case (ctl.radix)
                    ifmt_pkg::RADIX_OCT: dig_next[i] = {1'b0, magx[3*i +: 3]};
                    ifmt_pkg::RADIX_HEX: dig_next[i] = magx[4*i +: 4];
                    default:             dig_next[i] = 4'd0;
                endcase
            end
        end
        else if (ctl.dabble)
        begin
            dig_next = {corr[NDIG-1][2:0], corr[NDIG-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (ctl.shift)
        begin
            dig_next = {dig_reg[NDIG-2:0], 4'd0};
        end
    end

    // Hold the digits; payload only, no reset
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign top_digit = dig_reg[NDIG-1];

endmodule

// ===== src/integer_field_formatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats one integer as a printf-style field and emits its characters.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The block then
// loads the value, builds the decimal digits one bit at a time (decimal
// kinds only), drops leading zero digits one at a time, sizes the field to
// the larger of the width and the digits with sign and prefix, and then
// emits it. Characters appear on result, one per cycle with strobe high,
// the last one marked; they must be taken as they come, since this block
// cannot be held off. busy falls in the cycle the last character is shown,
// so a new transaction may start then.
// Unknown conversion kinds are taken and give no characters.
// ----------------------------------------------------------------------------
module integer_field_formatter_top #(
    parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = ifmt_pkg::MAX_FIELD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ifmt_pkg::request_t request,
    output logic               strobe,
    output ifmt_pkg::result_t  result
);

    localparam int WW   = ifmt_pkg::WIDTH_W;
    localparam int NDEC = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int NOCT = (VALUE_BITS + 2) / 3;
    localparam int NHEX = (VALUE_BITS + 3) / 4;
    localparam int NMAX = (NDEC > NOCT) ? NDEC : NOCT;
    localparam int NDIG = (NMAX > NHEX) ? NMAX : NHEX;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int BW   = $clog2(VALUE_BITS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DABBLE = 4'd1;
    localparam logic [3:0] ST_NORM   = 4'd2;
    localparam logic [3:0] ST_LEAD   = 4'd3;
    localparam logic [3:0] ST_SIGN   = 4'd4;
    localparam logic [3:0] ST_PFX0   = 4'd5;
    localparam logic [3:0] ST_PFXX   = 4'd6;
    localparam logic [3:0] ST_DIG    = 4'd7;
    localparam logic [3:0] ST_TRAIL  = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [BW-1:0]   bits_reg, bits_next;
    logic [WW-1:0]   w_reg, w_next;
    logic [WW-1:0]   pad_reg, pad_next;
    logic [WW-1:0]   left_reg, left_next;
    logic [1:0]      plen_reg, plen_next;
    logic            neg_reg, neg_next;
    logic            upper_reg, upper_next;
    logic            zp_reg, zp_next;
    logic            lj_reg, lj_next;
    logic            strobe_reg, strobe_next;
    ifmt_pkg::result_t result_reg, result_next;

    logic [VALUE_BITS-1:0] vext, mag;
    logic                  neg_in;
    logic [WW-1:0]         w_sat, n_chars;
    logic [3:0]            head_state;
    logic [3:0]            top_digit;
    logic                  emit;
    logic [7:0]            ch;
    ifmt_pkg::dig_cmd_t    dcmd;

    // Take the magnitude of the incoming value and cap the field width at MAX_FIELD
    always_comb
    begin
        vext   = VALUE_BITS'(request.value);
        neg_in = (request.opcode == ifmt_pkg::OP_SDEC) && vext[VALUE_BITS-1];
        mag    = neg_in ? (~vext + 1'b1) : vext;
        w_sat  = (request.field_width > WW'(MAX_FIELD)) ? WW'(MAX_FIELD)
                                                         : request.field_width;
    end

    // Unpadded field length, and the first state after padding: sign, prefix or digits
    assign n_chars    = WW'(cnt_reg) + WW'(plen_reg) + WW'(neg_reg);
    assign head_state = neg_reg ? ST_SIGN : ((plen_reg != 2'd0) ? ST_PFX0 : ST_DIG);

    // Sequence conversion and emission
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        w_next     = w_reg;
        pad_next   = pad_reg;
        left_next  = left_reg;
        plen_next  = plen_reg;
        neg_next   = neg_reg;
        upper_next = upper_reg;
        zp_next    = zp_reg;
        lj_next    = lj_reg;
        dcmd       = '0;
        emit       = 1'b0;
        ch         = ifmt_pkg::CH_SPACE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (request.opcode <= ifmt_pkg::OP_HEXU))
                begin
                    dcmd.load  = 1'b1;
                    cnt_next   = CW'(NDIG);
                    bits_next  = BW'(VALUE_BITS);
                    w_next     = w_sat;
                    neg_next   = neg_in;
                    zp_next    = request.zero_pad;
                    lj_next    = request.left_justify;
                    upper_next = (request.opcode == ifmt_pkg::OP_HEXU);
                    plen_next  = 2'd0;
                    case (request.opcode)
                        ifmt_pkg::OP_OCT:
                        begin
                            dcmd.radix = ifmt_pkg::RADIX_OCT;
                            plen_next  = request.alternate ? 2'd1 : 2'd0;
                            state_next = ST_NORM;
                        end
                        ifmt_pkg::OP_HEXL, ifmt_pkg::OP_HEXU:
                        begin
                            dcmd.radix = ifmt_pkg::RADIX_HEX;
                            plen_next  = request.alternate ? 2'd2 : 2'd0;
                            state_next = ST_NORM;
                        end
                        default:
                        begin
                            dcmd.radix = ifmt_pkg::RADIX_DEC;
                            state_next = ST_DABBLE;
                        end
                    endcase
                end
            end
            ST_DABBLE:
            begin
                dcmd.dabble = 1'b1;
                bits_next   = bits_reg - 1'b1;
                if (bits_reg == BW'(1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Drop leading zero digits, keep at least one
                if ((cnt_reg > CW'(1)) && (top_digit == 4'd0))
                begin
                    dcmd.shift = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                end
                else
                begin
                    pad_next  = (w_reg > n_chars) ? (w_reg - n_chars) : '0;
                    left_next = (w_reg > n_chars) ? w_reg : n_chars;
                    if (!lj_reg && (w_reg > n_chars))
                        state_next = ST_LEAD;
                    else
                        state_next = head_state;
                end
            end
            ST_LEAD:
            begin
                emit     = 1'b1;
                ch       = zp_reg ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
                pad_next = pad_reg - 1'b1;
                if (pad_reg == WW'(1))
                    state_next = head_state;
            end
            ST_SIGN:
            begin
                emit       = 1'b1;
                ch         = ifmt_pkg::CH_MINUS;
                state_next = ST_DIG;
            end
            ST_PFX0:
            begin
                emit       = 1'b1;
                ch         = ifmt_pkg::CH_ZERO;
                state_next = (plen_reg == 2'd2) ? ST_PFXX : ST_DIG;
            end
            ST_PFXX:
            begin
                emit       = 1'b1;
                ch         = ifmt_pkg::CH_X;
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                emit       = 1'b1;
                ch         = ifmt_pkg::digit_char(top_digit, upper_reg);
                dcmd.shift = 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = (lj_reg && (pad_reg != '0)) ? ST_TRAIL : ST_IDLE;
            end
            ST_TRAIL:
            begin
                emit     = 1'b1;
                ch       = ifmt_pkg::CH_SPACE;
                pad_next = pad_reg - 1'b1;
                if (pad_reg == WW'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Count characters down to mark the last one
        if (emit)
            left_next = left_reg - 1'b1;
        strobe_next           = emit;
        result_next.character = ch;
        result_next.last      = (left_reg == WW'(1));
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold working values and the output transaction
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        bits_reg   <= bits_next;
        w_reg      <= w_next;
        pad_reg    <= pad_next;
        left_reg   <= left_next;
        plen_reg   <= plen_next;
        neg_reg    <= neg_next;
        upper_reg  <= upper_next;
        zp_reg     <= zp_next;
        lj_reg     <= lj_next;
        result_reg <= result_next;
    end

    ifmt_digits #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_digits (
        .clk       (clk),
        .ctl       (dcmd),
        .mag       (mag),
        .top_digit (top_digit)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== src/ifmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter port checker
// Watches the top-level ports and checks transaction sequencing.
// ----------------------------------------------------------------------------
`include "integer_field_formatter_top_defines.svh"

module ifmt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input ifmt_pkg::request_t request,
    input logic               strobe,
    input ifmt_pkg::result_t  result
);

    logic take_bad;

    // Flag a transaction of unknown conversion kind being taken
    assign take_bad = start && !busy && (request.opcode > ifmt_pkg::OP_HEXU);

    // No character follows straight after the last one of a field
    `IFMT_ASSERT_NEXT(a_gap_after_last, strobe && result.last, !strobe, "character after last")

    // A character that is not the last leaves the block busy
    `IFMT_ASSERT_NOW(a_busy_mid_field, strobe && !result.last, busy, "idle inside a field")

    // Accepting a transaction never shows a character in the next cycle
    `IFMT_ASSERT_NEXT(a_no_early_char, start && !busy, !strobe, "character too early")

    // Unknown conversion kinds leave the block idle
    `IFMT_ASSERT_NEXT(a_unknown_idle, take_bad, !busy && !strobe, "unknown kind not dropped")

endmodule

bind integer_field_formatter_top ifmt_checker u_checker (.*);

// ===== tb/sv/integer_field_formatter_top_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter checker
// Watches the request and result channels of the formatter, works out the
// characters each accepted transaction must produce and compares every
// strobed character, in order, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module integer_field_formatter_top_check
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     strobe,
    input  result_t  result,
    output int       fail_count,
    output int       pending
);

    // Characters still owed by the block, oldest first
    result_t field_chars[$];
    int      mismatch_total;

    // Append the formatted characters of one transaction to field_chars
    function automatic void format_field(input request_t req);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            text [0:79];
        string                 digit_set;
        int unsigned           base;
        int unsigned           width;
        int unsigned           n;
        int unsigned           pad;
        int unsigned           total;
        logic                  neg;
        result_t               r;

        digit_set = "0123456789abcdef";
        case (req.opcode)
            OP_SDEC, OP_UDEC: base = 10;
            OP_OCT:           base = 8;
            OP_HEXL:          base = 16;
            OP_HEXU:
            begin
                base      = 16;
                digit_set = "0123456789ABCDEF";
            end
            default:          return;
        endcase

        width = 32'(req.field_width);
        if (width > MAX_FIELD)
            width = MAX_FIELD;

        // Take the magnitude, flipping negative signed values
        mag = req.value[VALUE_BITS-1:0];
        neg = (req.opcode == OP_SDEC) && mag[VALUE_BITS-1];
        if (neg)
            mag = ~mag + 1'b1;

        // Build the text backwards: digits, prefix, then sign
        n = 0;
        do
        begin
            text[n] = digit_set[mag % base];
            n++;
            mag = mag / base;
        end
        while (mag != 0);

        if (req.alternate)
        begin
            if (req.opcode == OP_HEXL || req.opcode == OP_HEXU)
            begin
                text[n]     = CH_X;
                text[n + 1] = CH_ZERO;
                n += 2;
            end
            else if (req.opcode == OP_OCT)
            begin
                text[n] = CH_ZERO;
                n++;
            end
        end
        if (neg)
        begin
            text[n] = CH_MINUS;
            n++;
        end

        pad   = (width > n) ? width - n : 0;
        total = n + pad;
        if (total > MAX_FIELD)
            total = MAX_FIELD;

        // Emit left or right justified
        for (int unsigned k = 0; k < total; k++)
        begin
            if (!req.left_justify)
            begin
                if (k < pad)
                    r.character = req.zero_pad ? CH_ZERO : CH_SPACE;
                else
                    r.character = text[n - 1 - (k - pad)];
            end
            else
            begin
                if (k < n)
                    r.character = text[n - 1 - k];
                else
                    r.character = CH_SPACE;
            end
            r.last = (k + 1 == total);
            field_chars.push_back(r);
        end
    endfunction

    // Compare strobed characters first, then queue up a newly taken transaction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (field_chars.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $realtime, result.character, result.last);
                    mismatch_total++;
                end
                else
                begin
                    want = field_chars.pop_front();
                    if (result.character !== want.character)
                    begin
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $realtime, want.character, result.character);
                        mismatch_total++;
                    end
                    if (result.last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $realtime, want.last, result.last);
                        mismatch_total++;
                    end
                end
            end
            if (start && !busy)
                format_field(request);
        end
        fail_count <= mismatch_total;
        pending    <= field_chars.size();
    end

endmodule

// ===== tb/sv/integer_field_formatter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives directed and random format transactions into the formatter with
// varying sender idle rates; a checker beside the block predicts and
// compares every character and hands back its failure count.
// ----------------------------------------------------------------------------
module integer_field_formatter_top_test;
    import ifmt_pkg::*;

    localparam int RANDOM_ITEMS = 156;
    localparam int DRAIN_CYCLES = 150;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     strobe;
    result_t  result;
    int       fail_count;
    int       pending;
    int       sender_idle_pct;

    integer_field_formatter_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    integer_field_formatter_top_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .strobe     (strobe),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic request_t make_request(input logic [2:0] op, input logic [31:0] val,
                                              input int w, input logic zp, input logic lj,
                                              input logic alt);
        request_t r;
        r.opcode       = op;
        r.value        = val;
        r.field_width  = w[WIDTH_W-1:0];
        r.zero_pad     = zp;
        r.left_justify = lj;
        r.alternate    = alt;
        return r;
    endfunction

    // Draw a random transaction, mostly valid kinds and narrow fields
    function automatic request_t draw_request();
        request_t r;
        int       pick;
        r = request_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 90)
            r.opcode = 3'($urandom_range(OP_SDEC, OP_HEXU));
        case ($urandom_range(0, 5))
            0: r.value = $urandom_range(0, 99);
            1: r.value = 32'h1 << $urandom_range(0, 31);
            2: r.value = -$urandom_range(1, 1000);
            3:
            begin
                pick = $urandom_range(0, 3);
                r.value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff :
                          (pick == 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            default: r.value = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70)
            r.field_width = WIDTH_W'($urandom_range(0, 16));
        else if (pick < 90)
            r.field_width = WIDTH_W'($urandom_range(17, 64));
        else
            r.field_width = WIDTH_W'($urandom_range(65, 127));
        return r;
    endfunction

    // Present one transaction after an optional idle gap and hold it until taken
    task automatic issue(input request_t r);
        int gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 60) : 0;
        if (gap > 0)
        begin
            start   <= 1'b0;
            request <= request_t'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        request         <= '0;
        sender_idle_pct  = 26;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        issue(make_request(OP_SDEC, 32'h0, 0, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, 32'hffff_ffff, 0, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, 32'h8000_0000, 0, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, 32'h7fff_ffff, 12, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, -32'sd5, 4, 1'b1, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, -32'sd5, 6, 1'b1, 1'b1, 1'b0));
        issue(make_request(OP_SDEC, 32'd42, 5, 1'b0, 1'b0, 1'b1));
        issue(make_request(OP_UDEC, 32'hffff_ffff, 1, 1'b0, 1'b0, 1'b1));
        issue(make_request(OP_UDEC, 32'd123456, 3, 1'b1, 1'b0, 1'b0));
        issue(make_request(OP_UDEC, 32'd0, 64, 1'b1, 1'b0, 1'b0));
        issue(make_request(OP_OCT, 32'h0, 0, 1'b0, 1'b0, 1'b1));
        issue(make_request(OP_OCT, 32'hffff_ffff, 20, 1'b1, 1'b0, 1'b1));
        issue(make_request(OP_OCT, 32'o1234567, 10, 1'b0, 1'b1, 1'b0));
        issue(make_request(OP_HEXL, 32'h0, 0, 1'b0, 1'b0, 1'b1));
        issue(make_request(OP_HEXL, 32'hdead_beef, 12, 1'b1, 1'b0, 1'b1));
        issue(make_request(OP_HEXU, 32'hcafe_babe, 0, 1'b0, 1'b0, 1'b1));
        issue(make_request(OP_HEXU, 32'h0000_0abc, 64, 1'b1, 1'b1, 1'b0));
        issue(make_request(OP_HEXU, 32'h1234_5678, 127, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_SDEC, 32'h8000_0000, 65, 1'b1, 1'b0, 1'b0));
        issue(make_request(OP_HEXL, 32'h0000_00ff, 64, 1'b0, 1'b1, 1'b1));
        issue(make_request(3'd5, 32'h1, 8, 1'b0, 1'b0, 1'b0));
        issue(make_request(3'd6, 32'hffff_ffff, 127, 1'b1, 1'b1, 1'b1));
        issue(make_request(3'd7, 32'h0, 0, 1'b0, 1'b0, 1'b0));
        issue(make_request(OP_UDEC, 32'd7, 2, 1'b0, 1'b1, 1'b0));

        // Random transactions in three idle phases
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
                sender_idle_pct = 46;
            else if (i == 2 * RANDOM_ITEMS / 3)
                sender_idle_pct = 0;
            issue(draw_request());
        end
        start <= 1'b0;

        // Drain outstanding characters, then let the block settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** integer_field_formatter_top: PASSED **");
        else
            $display("** integer_field_formatter_top: FAILED **");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("** integer_field_formatter_top: FAILED **");
        $finish;
    end

endmodule
